>>> rtl/pch_pkg.sv
// Shared types and constants for the PWM capture history block.
`default_nettype none
package pch_pkg;

  localparam int unsigned COUNT_W = 16;
  localparam int unsigned OP_W = 2;

  localparam logic [COUNT_W-1:0] MAX_PERIOD_RESET = 16'd12307;

  // Operation codes of a command word.
  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 2'd0,
    OP_RISE    = 2'd1,
    OP_FALL    = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  // Command word.
  typedef struct packed {
    logic [OP_W-1:0] operation;
    logic            select_period;
  } cmd_t;

  // Response word.
  typedef struct packed {
    logic [COUNT_W-1:0] sample;
    logic               last;
  } rsp_t;

  // Read stream sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_STREAM = 2'b10
  } state_t;

endpackage
`default_nettype wire

>>> rtl/pch_cfg_if.sv
// Configuration write channel carrying the max period register value.
`default_nettype none
interface pch_cfg_if import pch_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/pch_cmd_if.sv
// Command channel carrying tick, edge and read requests.
`default_nettype none
interface pch_cmd_if import pch_pkg::*; ();
  logic valid;
  logic ready;
  cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/pch_rsp_if.sv
// Response channel carrying stored samples of a history read.
`default_nettype none
interface pch_rsp_if import pch_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/pch_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module pch_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data register holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/pwm_capture_history_top.sv
// PWM capture with period and high-time history rings and a streaming read.
// Tick and edge words are accepted every cycle while no read is active and take
// effect next cycle. A read word streams HISTORY_DEPTH samples; the first is
// valid next cycle, then one per cycle while the sink takes them (one RAM read
// port per ring). The next command is accepted after the last sample is taken.
// Reset is synchronous; per-entry valid bits make both rings read as zero.
`default_nettype none
module pwm_capture_history_top import pch_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 8
) (
  input wire logic  clk,
  input wire logic  rst,
  pch_cfg_if.sink   cfg,
  pch_cmd_if.sink   cmd,
  pch_rsp_if.source rsp
);

  localparam int unsigned IDX_W = $clog2(HISTORY_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HISTORY_DEPTH - 1);

  logic [COUNT_W-1:0]       max_period;
  logic [COUNT_W-1:0]       tick_count;
  logic [IDX_W-1:0]         write_index;
  logic                     armed;
  logic [HISTORY_DEPTH-1:0] period_vld;
  logic [HISTORY_DEPTH-1:0] high_vld;

  state_t                   state;
  logic [IDX_W-1:0]         remaining;
  logic [IDX_W-1:0]         rd_addr;
  logic                     out_valid;
  logic                     out_last;
  logic                     out_sel;
  logic                     out_vld;

  logic                     cmd_fire;
  op_t                      op;
  logic                     start_read;
  logic                     issue;
  logic [IDX_W-1:0]         issue_addr;
  logic                     issue_last;
  logic [IDX_W-1:0]         issue_addr_next;
  logic                     period_wr;
  logic                     high_wr;
  logic [COUNT_W-1:0]       period_rd;
  logic [COUNT_W-1:0]       high_rd;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
    wrap_inc = (idx == IDX_LAST) ? '0 : idx + 1'b1;
  endfunction

  // Command decode.
  assign cmd.ready  = (state == ST_IDLE) && !out_valid;
  assign cmd_fire   = cmd.valid && cmd.ready;
  assign op         = op_t'(cmd.data.operation);
  assign start_read = cmd_fire && (op == OP_READ);
  assign period_wr  = cmd_fire && (op == OP_RISE) && (tick_count < max_period);
  assign high_wr    = cmd_fire && (op == OP_FALL) && armed;

  // Read issue: the first read goes out with the request, later ones when the
  // response register is free or being taken.
  assign issue      = start_read ||
                      ((state == ST_STREAM) && (!out_valid || rsp.ready));
  assign issue_addr = start_read ? write_index : rd_addr;
  assign issue_last = start_read ? (HISTORY_DEPTH == 1) : (remaining == IDX_W'(1));
  assign issue_addr_next = wrap_inc(issue_addr);

  // Configuration register.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_period <= MAX_PERIOD_RESET;
    end else if (cfg.valid) begin
      max_period <= cfg.data;
    end
  end

  // Tick counter, arming and write index.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      write_index <= '0;
      armed       <= 1'b0;
      period_vld  <= '0;
      high_vld    <= '0;
    end else if (cmd_fire) begin
      case (op)
        OP_TICK: begin
          tick_count <= tick_count + 1'b1;
        end
        OP_RISE: begin
          tick_count <= '0;
          if (period_wr) begin
            period_vld[write_index] <= 1'b1;
          end
        end
        OP_FALL: begin
          if (!armed) begin
            armed <= 1'b1;
          end else begin
            high_vld[write_index] <= 1'b1;
            write_index           <= wrap_inc(write_index);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Ring storage.
  pch_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_period_ram (
    .clk     (clk),
    .wr_en   (period_wr),
    .wr_addr (write_index),
    .wr_data (tick_count),
    .rd_en   (issue),
    .rd_addr (issue_addr),
    .rd_data (period_rd)
  );

  pch_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_high_ram (
    .clk     (clk),
    .wr_en   (high_wr),
    .wr_addr (write_index),
    .wr_data (tick_count),
    .rd_en   (issue),
    .rd_addr (issue_addr),
    .rd_data (high_rd)
  );

  // Read stream sequencer and response control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (start_read) begin
            state <= ST_STREAM;
          end
        end
        ST_STREAM: begin
          if (issue && issue_last) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Stream payload bookkeeping.
  always_ff @(posedge clk) begin
    if (start_read) begin
      out_sel   <= cmd.data.select_period;
      remaining <= IDX_LAST;
    end else if (issue) begin
      remaining <= remaining - 1'b1;
    end
    if (issue) begin
      rd_addr  <= issue_addr_next;
      out_last <= issue_last;
      out_vld  <= (start_read ? cmd.data.select_period : out_sel) ?
                  period_vld[issue_addr] : high_vld[issue_addr];
    end
  end

  // Response word; an entry never written since reset reads as zero.
  assign rsp.valid       = out_valid;
  assign rsp.data.last   = out_last;
  assign rsp.data.sample = !out_vld ? '0 : (out_sel ? period_rd : high_rd);

  // A new read is never issued over a response the sink has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    issue |-> !(out_valid && !rsp.ready))
    else $error("read issued over a pending response");

  // After the last sample is taken the block is ready for a command.
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.ready && rsp.data.last) |=> cmd.ready)
    else $error("block not idle after last sample");

  // The write index stays inside the ring.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    write_index <= IDX_LAST)
    else $error("write index out of range");

  // Streaming always has reads left to issue.
  a_stream_remaining: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STREAM) |-> (remaining != '0))
    else $error("stream state with no reads left");

  // Ring contents do not change while a read stream is in progress.
  a_no_write_in_stream: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STREAM) |-> !(period_wr || high_wr))
    else $error("ring written during a read stream");

endmodule
`default_nettype wire
